[sv/rtcr_pkg.sv]
// ----------------------------------------------------------------------------
// rtcr_pkg
// Shared types, event codes and constants of the radio time code receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcr_pkg;

  localparam int FRAME_BITS = 59;
  localparam int TIME_WIDTH = 16;
  localparam int IDX_WIDTH  = $clog2(FRAME_BITS + 1);

  localparam int NUM_REGS   = 8;
  localparam int REG_WIDTH  = 12;
  localparam int ADDR_WIDTH = 5;

  localparam logic [2:0] REG_SECOND_MIN = 3'd0;
  localparam logic [2:0] REG_SECOND_MAX = 3'd1;
  localparam logic [2:0] REG_MINUTE_MIN = 3'd2;
  localparam logic [2:0] REG_MINUTE_MAX = 3'd3;
  localparam logic [2:0] REG_ZERO_MIN   = 3'd4;
  localparam logic [2:0] REG_ZERO_MAX   = 3'd5;
  localparam logic [2:0] REG_ONE_MIN    = 3'd6;
  localparam logic [2:0] REG_ONE_MAX    = 3'd7;

  localparam logic [REG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
    12'd900, 12'd1100, 12'd1900, 12'd2100, 12'd70, 12'd130, 12'd170, 12'd230
  };

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SECOND  = 3'd1;
  localparam logic [2:0] EV_MINUTE  = 3'd2;
  localparam logic [2:0] EV_ZERO    = 3'd3;
  localparam logic [2:0] EV_ONE     = 3'd4;
  localparam logic [2:0] EV_INVALID = 3'd5;

  localparam logic [11:0] YEAR_BASE  = 12'd2000;
  localparam logic [11:0] YEAR_RESET = 12'd2017;

  typedef struct packed {
    logic                  signal_level;
    logic [TIME_WIDTH-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [6:0]  time_minute;
    logic [5:0]  time_hour;
    logic [5:0]  date_day;
    logic [2:0]  date_weekday;
    logic [4:0]  date_month;
    logic [11:0] date_year;
    logic        minute_updated;
    logic        clock_set;
    logic        date_updated;
    logic        error_flag;
    logic        decode_ok;
  } result_t;

  typedef struct packed {
    logic        marker_ok;
    logic        minute_ok;
    logic        hour_ok;
    logic        date_ok;
    logic        weekday_ok;
    logic [6:0]  minute;
    logic [5:0]  hour;
    logic [2:0]  weekday;
    logic [5:0]  day;
    logic [4:0]  month;
    logic [11:0] year;
  } frame_info_t;

  function automatic logic [7:0] bcd_value(logic [3:0] units, logic [3:0] tens);
    return {4'b0, units} + {4'b0, tens} * 8'd10;
  endfunction

endpackage

`default_nettype wire

[sv/rtcr_frame_decode.sv]
// ----------------------------------------------------------------------------
// rtcr_frame_decode
// Parity checks and BCD decode of one stored time code frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcr_frame_decode
  import rtcr_pkg::*;
(
  input  wire logic [FRAME_BITS-1:0] frame,
  output frame_info_t                info
);

  logic [7:0] minute_raw;
  logic [7:0] hour_raw;
  logic [7:0] day_raw;
  logic [7:0] month_raw;
  logic [7:0] year_raw;

  assign minute_raw = bcd_value(frame[24:21], {1'b0, frame[27:25]});
  assign hour_raw   = bcd_value(frame[32:29], {2'b0, frame[34:33]});
  assign day_raw    = bcd_value(frame[39:36], {2'b0, frame[41:40]});
  assign month_raw  = bcd_value(frame[48:45], {3'b0, frame[49]});
  assign year_raw   = bcd_value(frame[53:50], frame[57:54]);

  always_comb begin
    info.marker_ok  = frame[20];
    info.minute_ok  = (^frame[27:21]) == frame[28];
    info.hour_ok    = (^frame[34:29]) == frame[35];
    info.date_ok    = (^frame[57:36]) == frame[58];
    info.weekday_ok = frame[44:42] != 3'd0;
    info.minute     = minute_raw[6:0];
    info.hour       = hour_raw[5:0];
    info.weekday    = frame[44:42];
    info.day        = day_raw[5:0];
    info.month      = month_raw[4:0];
    info.year       = {4'b0, year_raw} + YEAR_BASE;
  end

endmodule

`default_nettype wire

[sv/radio_time_code_receiver_unit.sv]
// ----------------------------------------------------------------------------
// radio_time_code_receiver_unit
// Edge classification, frame capture and time/date decode of a radio time code.
// ----------------------------------------------------------------------------
// Pipeline: the tick register feeds the result register. Throughput: one tick
// per cycle unless result_ready back-pressure stalls it; the edge window compares
// and the frame decode sit between the tick register and the result register.
// Reset: synchronous; clears the pipeline, loads the default windows, clears
// the frame and sync state and sets the date to its default.
`default_nettype none

module radio_time_code_receiver_unit
  import rtcr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  tick_valid,
  output logic                       tick_ready,
  input  wire tick_t                 tick,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [REG_WIDTH-1:0] cfg [NUM_REGS];

  logic  stage_valid;
  tick_t stage;
  logic  advance;
  logic  stage_move;

  logic                  prev_level;
  logic [TIME_WIDTH-1:0] fall_stamp;
  logic [FRAME_BITS-1:0] frame_bits;
  logic [IDX_WIDTH-1:0]  bit_index;
  logic                  synced;
  logic [6:0]            minute_reg;
  logic [5:0]            hour_reg;
  logic [5:0]            day_reg;
  logic [2:0]            weekday_reg;
  logic [4:0]            month_reg;
  logic [11:0]           year_reg;
  logic                  error_flag;
  logic                  decode_ok;

  logic                  prev_level_next;
  logic [TIME_WIDTH-1:0] fall_stamp_next;
  logic [FRAME_BITS-1:0] frame_bits_next;
  logic [IDX_WIDTH-1:0]  bit_index_next;
  logic                  synced_next;
  logic [6:0]            minute_reg_next;
  logic [5:0]            hour_reg_next;
  logic [5:0]            day_reg_next;
  logic [2:0]            weekday_reg_next;
  logic [4:0]            month_reg_next;
  logic [11:0]           year_reg_next;
  logic                  error_flag_next;
  logic                  decode_ok_next;

  logic [TIME_WIDTH-1:0] delta;
  logic [2:0]            ev;
  logic                  min_up;
  logic                  clk_set;
  logic                  date_up;
  logic                  room;
  frame_info_t           info;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {{(32 - REG_WIDTH){1'b0}}, cfg[paddr[4:2]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg[i] <= REG_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg[paddr[4:2]] <= pwdata[REG_WIDTH-1:0];
    end
  end

  // pipeline control
  assign stage_move = !result_valid || result_ready;
  assign advance    = stage_valid && stage_move;
  assign tick_ready = !stage_valid || stage_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (tick_ready) begin
      stage_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ready && tick_valid) begin
      stage <= tick;
    end
  end

  rtcr_frame_decode u_decode (
    .frame (frame_bits),
    .info  (info)
  );

  function automatic logic in_win(logic [TIME_WIDTH-1:0] d, logic [REG_WIDTH-1:0] lo,
                                  logic [REG_WIDTH-1:0] hi);
    return (TIME_WIDTH'(lo) <= d) && (d <= TIME_WIDTH'(hi));
  endfunction

  // classify edge
  always_comb begin
    delta = stage.now_ms - fall_stamp;
    ev    = EV_NONE;
    if (stage.signal_level != prev_level) begin
      if (!stage.signal_level) begin
        if (in_win(delta, cfg[REG_SECOND_MIN], cfg[REG_SECOND_MAX])) begin
          ev = EV_SECOND;
        end else if (in_win(delta, cfg[REG_MINUTE_MIN], cfg[REG_MINUTE_MAX])) begin
          ev = EV_MINUTE;
        end else begin
          ev = EV_INVALID;
        end
      end else begin
        if (in_win(delta, cfg[REG_ZERO_MIN], cfg[REG_ZERO_MAX])) begin
          ev = EV_ZERO;
        end else if (in_win(delta, cfg[REG_ONE_MIN], cfg[REG_ONE_MAX])) begin
          ev = EV_ONE;
        end else begin
          ev = EV_INVALID;
        end
      end
    end
  end

  // next state
  always_comb begin
    prev_level_next  = stage.signal_level;
    fall_stamp_next  = fall_stamp;
    frame_bits_next  = frame_bits;
    bit_index_next   = bit_index;
    synced_next      = synced;
    minute_reg_next  = minute_reg;
    hour_reg_next    = hour_reg;
    day_reg_next     = day_reg;
    weekday_reg_next = weekday_reg;
    month_reg_next   = month_reg;
    year_reg_next    = year_reg;
    error_flag_next  = error_flag;
    decode_ok_next   = decode_ok;
    min_up           = 1'b0;
    clk_set          = 1'b0;
    date_up          = 1'b0;
    room             = synced && (bit_index < IDX_WIDTH'(FRAME_BITS));

    if (stage.signal_level != prev_level && !stage.signal_level) begin
      fall_stamp_next = stage.now_ms;
    end

    case (ev)
      EV_ZERO, EV_ONE: begin
        if (room) begin
          frame_bits_next[bit_index] = (ev == EV_ONE);
        end
      end
      EV_SECOND: begin
        if (room) begin
          bit_index_next = bit_index + IDX_WIDTH'(1);
        end
      end
      EV_MINUTE: begin
        bit_index_next = '0;
        if (!synced) begin
          synced_next = 1'b1;
        end else begin
          error_flag_next = 1'b0;
          if (!info.marker_ok || !info.minute_ok) begin
            decode_ok_next = 1'b0;
          end else begin
            minute_reg_next = info.minute;
            min_up          = 1'b1;
            if (info.hour_ok) begin
              hour_reg_next = info.hour;
              clk_set       = 1'b1;
              if (info.weekday_ok) begin
                weekday_reg_next = info.weekday;
              end
              if (info.date_ok) begin
                day_reg_next   = info.day;
                month_reg_next = info.month;
                year_reg_next  = info.year;
                date_up        = 1'b1;
                decode_ok_next = 1'b1;
              end else begin
                decode_ok_next = 1'b0;
              end
            end
          end
        end
      end
      EV_INVALID: begin
        error_flag_next = 1'b1;
        decode_ok_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level  <= 1'b1;
      fall_stamp  <= '0;
      frame_bits  <= '0;
      bit_index   <= '0;
      synced      <= 1'b0;
      minute_reg  <= '0;
      hour_reg    <= '0;
      day_reg     <= 6'd1;
      weekday_reg <= 3'd1;
      month_reg   <= 5'd1;
      year_reg    <= YEAR_RESET;
      error_flag  <= 1'b0;
      decode_ok   <= 1'b0;
    end else if (advance) begin
      prev_level  <= prev_level_next;
      fall_stamp  <= fall_stamp_next;
      frame_bits  <= frame_bits_next;
      bit_index   <= bit_index_next;
      synced      <= synced_next;
      minute_reg  <= minute_reg_next;
      hour_reg    <= hour_reg_next;
      day_reg     <= day_reg_next;
      weekday_reg <= weekday_reg_next;
      month_reg   <= month_reg_next;
      year_reg    <= year_reg_next;
      error_flag  <= error_flag_next;
      decode_ok   <= decode_ok_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_move) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.event_code     <= ev;
      result.time_minute    <= minute_reg_next;
      result.time_hour      <= hour_reg_next;
      result.date_day       <= day_reg_next;
      result.date_weekday   <= weekday_reg_next;
      result.date_month     <= month_reg_next;
      result.date_year      <= year_reg_next;
      result.minute_updated <= min_up;
      result.clock_set      <= clk_set;
      result.date_updated   <= date_up;
      result.error_flag     <= error_flag_next;
      result.decode_ok      <= decode_ok_next;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    bit_index <= IDX_WIDTH'(FRAME_BITS))
    else $error("bit index beyond frame length");

  a_unsynced_index: assert property (@(posedge clk) disable iff (rst)
    !synced |-> bit_index == '0)
    else $error("bit index advanced before sync");

  a_update_on_marker: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.minute_updated |-> result.event_code == EV_MINUTE)
    else $error("minute update without minute marker");

  a_update_chain: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.date_updated |->
      result.clock_set && result.minute_updated && result.decode_ok)
    else $error("date update without time update");

endmodule

`default_nettype wire
